// ===== rtl/core/rds_pkg.sv =====
// ----------------------------------------------------------------------------
// rds_pkg
// Opcodes, block ids and the result record of the RDS block decoder.
// ----------------------------------------------------------------------------
package rds_pkg;

	localparam logic [1:0] OP_BLOCK = 2'd0;
	localparam logic [1:0] OP_TICK  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam logic [2:0] BLK_A    = 3'd0;
	localparam logic [2:0] BLK_B    = 3'd1;
	localparam logic [2:0] BLK_D    = 3'd3;
	localparam logic [2:0] BLK_CP   = 3'd4;
	localparam logic [2:0] NO_BLOCK = 3'd7;

	localparam logic [7:0] WINDOW_RESET = 8'd6;
	localparam logic [3:0] GROUP_BASIC  = 4'd0;
	localparam logic [3:0] GROUP_FAST   = 4'd15;
	localparam logic [3:0] PAIRS_ALL    = 4'hF;

	typedef struct packed {
		logic [2:0]  result_type;
		logic [15:0] pi_code;
		logic [63:0] name_text;
		logic [3:0]  pair_mask;
		logic        name_complete;
		logic [15:0] group_a0_count;
	} result_t;

endpackage

// ===== rtl/core/rds_core.sv =====
// ----------------------------------------------------------------------------
// rds_core
// Decoder state and its next-state logic; updates on each accepted item.
// ----------------------------------------------------------------------------
module rds_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic             cfg_we,
	input  logic [7:0]       cfg_data,
	input  logic [1:0]       opcode,
	input  logic [2:0]       block_id,
	input  logic [1:0]       error_count,
	input  logic             in_sync,
	input  logic             in_reset,
	input  logic             overflow,
	input  logic [15:0]      block_word,
	output rds_pkg::result_t res_d
);
	import rds_pkg::*;

	logic [7:0]        window_ticks_q;
	logic [15:0]       pi_q, pi_d;
	logic [3:0][15:0]  name_q, name_d;
	logic [3:0]        pairs_q, pairs_d;
	logic              complete_q, complete_d;
	logic [3:0]        grp_q, grp_d;
	logic              ver_q, ver_d;
	logic [4:0]        seg_q, seg_d;
	logic [15:0]       cnt_q, cnt_d;
	logic              win_q, win_d;
	logic [7:0]        timer_q, timer_d;
	logic [7:0]        last_status_q, last_status_d;
	logic [15:0]       last_word_q, last_word_d;
	logic              last_valid_q, last_valid_d;
	logic [7:0]        status;
	logic [2:0]        rtype;
	logic [3:0]        pairs_set;

	assign status    = {in_sync, overflow, in_reset, block_id, error_count};
	assign pairs_set = pairs_q | (4'b0001 << seg_q[1:0]);

	always_comb begin
		pi_d          = pi_q;
		name_d        = name_q;
		pairs_d       = pairs_q;
		complete_d    = complete_q;
		grp_d         = grp_q;
		ver_d         = ver_q;
		seg_d         = seg_q;
		cnt_d         = cnt_q;
		win_d         = win_q;
		timer_d       = timer_q;
		last_status_d = last_status_q;
		last_word_d   = last_word_q;
		last_valid_d  = last_valid_q;
		rtype         = NO_BLOCK;
		case (opcode)
			OP_BLOCK: begin
				if (!(last_valid_q && status == last_status_q && block_word == last_word_q)) begin
					last_status_d = status;
					last_word_d   = block_word;
					last_valid_d  = 1'b1;
					if (in_sync && !in_reset) begin
						rtype = block_id;
						if (error_count == 2'd0) begin
							case (block_id) inside
								BLK_A, BLK_CP: begin
									pi_d = block_word;
								end
								BLK_B: begin
									grp_d = block_word[15:12];
									ver_d = block_word[11];
									seg_d = block_word[4:0];
									if (block_word[15:12] == GROUP_BASIC) begin
										if (!block_word[11])
											cnt_d = cnt_q + 16'd1;
										win_d   = 1'b1;
										timer_d = window_ticks_q;
									end
								end
								BLK_D: begin
									if (grp_q == GROUP_BASIC) begin
										if (win_q) begin
											name_d[~seg_q[1:0]] = block_word;
											pairs_d = pairs_set;
											if (pairs_set == PAIRS_ALL)
												complete_d = 1'b1;
											win_d = 1'b0;
										end
									end else if (grp_q == GROUP_FAST && ver_q) begin
										seg_d = block_word[4:0];
									end
								end
								default: ;
							endcase
						end
					end
				end
			end
			OP_TICK: begin
				if (win_q) begin
					if (timer_q <= 8'd1) begin
						timer_d = 8'd0;
						win_d   = 1'b0;
					end else begin
						timer_d = timer_q - 8'd1;
					end
				end
			end
			OP_CLEAR: begin
				pi_d       = '0;
				name_d     = '0;
				pairs_d    = '0;
				complete_d = 1'b0;
				seg_d      = '0;
				cnt_d      = '0;
			end
			default: ;
		endcase
	end

	always_comb begin
		res_d.result_type    = rtype;
		res_d.pi_code        = pi_d;
		res_d.name_text      = name_d;
		res_d.pair_mask      = pairs_d;
		res_d.name_complete  = complete_d;
		res_d.group_a0_count = cnt_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_ticks_q <= WINDOW_RESET;
		end else if (cfg_we) begin
			window_ticks_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pi_q          <= '0;
			name_q        <= '0;
			pairs_q       <= '0;
			complete_q    <= 1'b0;
			grp_q         <= '0;
			ver_q         <= 1'b0;
			seg_q         <= '0;
			cnt_q         <= '0;
			win_q         <= 1'b0;
			timer_q       <= '0;
			last_status_q <= '0;
			last_word_q   <= '0;
			last_valid_q  <= 1'b0;
		end else if (accept) begin
			pi_q          <= pi_d;
			name_q        <= name_d;
			pairs_q       <= pairs_d;
			complete_q    <= complete_d;
			grp_q         <= grp_d;
			ver_q         <= ver_d;
			seg_q         <= seg_d;
			cnt_q         <= cnt_d;
			win_q         <= win_d;
			timer_q       <= timer_d;
			last_status_q <= last_status_d;
			last_word_q   <= last_word_d;
			last_valid_q  <= last_valid_d;
		end
	end

endmodule

// ===== rtl/core/rds_out_reg.sv =====
// ----------------------------------------------------------------------------
// rds_out_reg
// Result register with valid/ready; can_load is high whenever it is empty or drained.
// ----------------------------------------------------------------------------
module rds_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  rds_pkg::result_t res_d,
	input  logic             out_ready,
	output logic             out_valid,
	output logic             can_load,
	output rds_pkg::result_t res_q
);
	import rds_pkg::*;

	assign can_load = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			res_q <= res_d;
	end

endmodule

// ===== rtl/core/rds_block_decoder_top.sv =====
// ----------------------------------------------------------------------------
// rds_block_decoder_top
// RDS block decoder: PI code, 0A group count and eight-character name.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries one transaction per block, tick
// or clear; output channel (out_valid/out_ready) returns one result per
// input transaction, in order.
// The decoder state updates at the input accept edge; the result is
// registered, so it appears in the cycle after acceptance.
// Throughput is one transaction per cycle while the receiver takes each
// result, set by the single result register: in_ready is high while that
// register is empty or being drained in the same cycle.
// When the receiver stalls, the result holds and in_ready drops until the
// result is taken.
// cfg_we writes window_ticks from cfg_data; write only while idle.
// Reset (arst_n low) clears all decoded data and the repeat history, sets
// window_ticks to 6 and empties the result register.
// ----------------------------------------------------------------------------
module rds_block_decoder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic [2:0]  block_id,
	input  logic [1:0]  error_count,
	input  logic        in_sync,
	input  logic        in_reset,
	input  logic        overflow,
	input  logic [15:0] block_word,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  result_type,
	output logic [15:0] pi_code,
	output logic [63:0] name_text,
	output logic [3:0]  pair_mask,
	output logic        name_complete,
	output logic [15:0] group_a0_count
);
	import rds_pkg::*;

	result_t res_d;
	result_t res_q;
	logic    accept;

	assign accept = in_valid && in_ready;

	rds_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.opcode      (opcode),
		.block_id    (block_id),
		.error_count (error_count),
		.in_sync     (in_sync),
		.in_reset    (in_reset),
		.overflow    (overflow),
		.block_word  (block_word),
		.res_d       (res_d)
	);

	rds_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept),
		.res_d     (res_d),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.can_load  (in_ready),
		.res_q     (res_q)
	);

	assign result_type    = res_q.result_type;
	assign pi_code        = res_q.pi_code;
	assign name_text      = res_q.name_text;
	assign pair_mask      = res_q.pair_mask;
	assign name_complete  = res_q.name_complete;
	assign group_a0_count = res_q.group_a0_count;

endmodule

// ===== rtl/core/rds_chk.sv =====
// ----------------------------------------------------------------------------
// rds_chk
// Port-level checks of the RDS block decoder, bound to the top level.
// ----------------------------------------------------------------------------
module rds_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [1:0]  opcode,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  result_type,
	input logic [15:0] pi_code,
	input logic [63:0] name_text,
	input logic [3:0]  pair_mask,
	input logic        name_complete,
	input logic [15:0] group_a0_count
);
	import rds_pkg::*;

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_type) && $stable(pi_code)
			&& $stable(name_text) && $stable(pair_mask) && $stable(group_a0_count))
		else $error("result changed while stalled");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input not ready with empty result register");

	a_accept_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted transaction produced no result");

	a_nonblock_type: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && opcode != OP_BLOCK |=> result_type == NO_BLOCK)
		else $error("tick or clear reported a block type");

	a_complete_mask: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && name_complete |-> pair_mask == PAIRS_ALL)
		else $error("name complete without all pairs");

endmodule

bind rds_block_decoder_top rds_chk u_chk (.*);
